/* rtl/sid_pkg.sv */
// Shared types and constants for the signed integer divider.
package sid_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    // Bit positions of the status flags in m_tuser
    localparam int USER_DBZ_BIT = 0;
    localparam int USER_OVF_BIT = 1;
    localparam int USER_W       = 2;

    // Per-transaction side information that rides along the cell chain
    typedef struct packed {
        logic valid;
        logic neg;
        logic dbz;
        logic ovf;
    } sid_ctrl_t;

endpackage

/* rtl/sid_cell.sv */
// One restoring division cell: resolves one quotient bit and hands the word on.
module sid_cell #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  sid_pkg::sid_ctrl_t    ctrl_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] dvd_in,
    input  logic [DATA_WIDTH-1:0] dsr_in,
    output sid_pkg::sid_ctrl_t    ctrl_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] dvd_out,
    output logic [DATA_WIDTH-1:0] dsr_out
);
    import sid_pkg::*;

    sid_ctrl_t             ctrl_reg, ctrl_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0] dsr_reg;
    logic [DATA_WIDTH:0]   trial;
    logic                  qbit;

    always_comb
    begin
        // Shift the next dividend bit into the partial remainder and try a subtract
        trial     = {rem_in, dvd_in[DATA_WIDTH-1]} - {1'b0, dsr_in};
        qbit      = !trial[DATA_WIDTH];
        rem_next  = qbit ? trial[DATA_WIDTH-1:0] : {rem_in[DATA_WIDTH-2:0], dvd_in[DATA_WIDTH-1]};
        dvd_next  = {dvd_in[DATA_WIDTH-2:0], qbit};
        ctrl_next = ctrl_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            dsr_reg <= dsr_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign dvd_out  = dvd_reg;
    assign dsr_out  = dsr_reg;

    // Partial remainder stays below the divisor magnitude for a nonzero divisor
    a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.valid && !ctrl_reg.dbz) |-> (rem_reg < dsr_reg))
        else $error("partial remainder not below divisor");

endmodule

/* rtl/signed_integer_divider.sv */
// Signed integer divider, quotient truncated toward zero, built as a chain of division cells.
//
// Usage:
//   Input channel s_*: s_tdata carries the dividend in the low DATA_WIDTH bits and the
//   divisor in the next DATA_WIDTH bits. A transaction is taken when s_tvalid and
//   s_tready are both high.
//   Output channel m_*: m_tdata carries the quotient, m_tuser the divide-by-zero flag
//   (bit 0) and the overflow flag (bit 1).
//   A result passes through a head register that takes magnitudes, a chain of
//   DATA_WIDTH cells that each resolve one quotient bit, and the output register
//   that applies the sign fix-up. The chain holds up to DATA_WIDTH + 2 transactions
//   at once and takes one new transaction every cycle while the output is not stalled.
//   A zero divisor returns quotient 0 with divide_by_zero set; the most negative
//   dividend over minus one returns the largest positive value with overflow set.
//   Reset clears all valid bits; the block is empty and ready after reset.
//   When the receiver holds m_tready low with a result pending, the whole chain
//   stalls and s_tready drops until the result is taken.
module signed_integer_divider #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // dividend, divisor, zero padding
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]            s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // quotient, zero padding
    output logic [((DATA_WIDTH+7)/8)*8-1:0]              m_tdata,
    // divide_by_zero, overflow
    output logic [sid_pkg::USER_W-1:0]                   m_tuser
);
    import sid_pkg::*;

    localparam int OUT_TDATA_W = ((DATA_WIDTH+7)/8)*8;
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONE = {DATA_WIDTH{1'b1}};

    logic                  adv;
    logic [DATA_WIDTH-1:0] a_in, b_in;

    sid_ctrl_t             ctrl_w [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dvd_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dsr_w  [0:DATA_WIDTH];

    sid_ctrl_t             head_ctrl_reg, head_ctrl_next;
    logic [DATA_WIDTH-1:0] head_dvd_reg, head_dvd_next;
    logic [DATA_WIDTH-1:0] head_dsr_reg, head_dsr_next;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] quot_reg, quot_next;
    logic [USER_W-1:0]     user_reg, user_next;

    // Advance the whole chain unless a finished result is waiting on the receiver
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    assign a_in = s_tdata[DATA_WIDTH-1:0];
    assign b_in = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    // Head stage: magnitudes, result sign and special cases
    always_comb
    begin
        head_ctrl_next.valid = s_tvalid;
        head_ctrl_next.neg   = a_in[DATA_WIDTH-1] ^ b_in[DATA_WIDTH-1];
        head_ctrl_next.dbz   = (b_in == '0);
        head_ctrl_next.ovf   = (a_in == MIN_VAL) && (b_in == ALL_ONE);
        head_dvd_next        = a_in[DATA_WIDTH-1] ? (~a_in + 1'b1) : a_in;
        head_dsr_next        = b_in[DATA_WIDTH-1] ? (~b_in + 1'b1) : b_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            head_ctrl_reg <= head_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            head_dvd_reg <= head_dvd_next;
            head_dsr_reg <= head_dsr_next;
        end
    end

    assign ctrl_w[0] = head_ctrl_reg;
    assign rem_w[0]  = '0;
    assign dvd_w[0]  = head_dvd_reg;
    assign dsr_w[0]  = head_dsr_reg;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        sid_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .ctrl_in  (ctrl_w[i]),
            .rem_in   (rem_w[i]),
            .dvd_in   (dvd_w[i]),
            .dsr_in   (dsr_w[i]),
            .ctrl_out (ctrl_w[i+1]),
            .rem_out  (rem_w[i+1]),
            .dvd_out  (dvd_w[i+1]),
            .dsr_out  (dsr_w[i+1])
        );
    end

    // Tail stage: apply sign and special cases into the output register
    always_comb
    begin
        out_valid_next         = ctrl_w[DATA_WIDTH].valid;
        user_next              = '0;
        user_next[USER_DBZ_BIT] = ctrl_w[DATA_WIDTH].dbz;
        user_next[USER_OVF_BIT] = ctrl_w[DATA_WIDTH].ovf && !ctrl_w[DATA_WIDTH].dbz;
        if (ctrl_w[DATA_WIDTH].dbz)
        begin
            quot_next = '0;
        end
        else if (ctrl_w[DATA_WIDTH].ovf)
        begin
            quot_next = MAX_VAL;
        end
        else if (ctrl_w[DATA_WIDTH].neg)
        begin
            quot_next = ~dvd_w[DATA_WIDTH] + 1'b1;
        end
        else
        begin
            quot_next = dvd_w[DATA_WIDTH];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quot_reg <= quot_next;
            user_reg <= user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(quot_reg);
    assign m_tuser  = user_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[USER_DBZ_BIT] && m_tuser[USER_OVF_BIT]))
        else $error("divide-by-zero and overflow both set");

    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[USER_DBZ_BIT]) |-> (quot_reg == '0))
        else $error("divide by zero with nonzero quotient");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[USER_OVF_BIT]) |-> (quot_reg == MAX_VAL))
        else $error("overflow without saturated quotient");

endmodule

/* verif/tb_signed_integer_divider.sv */
// Self-checking testbench for signed_integer_divider: directed and random divisions.
`timescale 1ns / 100ps

module tb_signed_integer_divider;

    localparam int DW       = sid_pkg::DATA_WIDTH_DEF;
    localparam int S_BITS   = ((2*DW+7)/8)*8;
    localparam int M_BITS   = ((DW+7)/8)*8;
    localparam int LATENCY  = DW + 2;
    localparam int HOLD_OFF = 200;

    localparam logic [DW-1:0] MOST_NEG  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINUS_ONE = {DW{1'b1}};

    typedef struct packed {
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } div_operands_t;

    typedef struct packed {
        logic [DW-1:0] quotient;
        logic          divide_by_zero;
        logic          overflow;
    } div_result_t;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [S_BITS-1:0]           s_tdata  = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [M_BITS-1:0]           m_tdata;
    logic [sid_pkg::USER_W-1:0]  m_tuser;

    div_operands_t pending_divisions[$];
    div_result_t   expected_quotients[$];

    int failures       = 0;
    int quotients_seen = 0;
    int stall_trigger  = -1;
    int tx_gap         = 0;
    int rx_gap         = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit tx_idle_on     = 1'b1;
    bit rx_idle_on     = 1'b1;

    signed_integer_divider #(.DATA_WIDTH(DW)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Truncating signed division with the block's flag conventions
    function automatic div_result_t predict_division(logic [DW-1:0] num, logic [DW-1:0] den);
        div_result_t   r;
        logic [DW-1:0] num_mag;
        logic [DW-1:0] den_mag;
        logic [DW-1:0] quo_mag;
        r = '0;
        num_mag = num[DW-1] ? -num : num;
        den_mag = den[DW-1] ? -den : den;
        if (den == '0)
        begin
            r.divide_by_zero = 1'b1;
        end
        else if (num == MOST_NEG && den == MINUS_ONE)
        begin
            r.overflow = 1'b1;
            r.quotient = MOST_POS;
        end
        else
        begin
            quo_mag = num_mag / den_mag;
            r.quotient = (num[DW-1] ^ den[DW-1]) ? -quo_mag : quo_mag;
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DW-1:0] rand_word();
        return DW'({$urandom(), $urandom()});
    endfunction

    function automatic logic [DW-1:0] small_signed(int max_mag);
        logic [DW-1:0] v;
        v = DW'($urandom_range(1, max_mag));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic div_operands_t random_operands();
        div_operands_t        op;
        logic signed [DW-1:0] k;
        int                   pick;
        pick = $urandom_range(0, 99);
        op.dividend = rand_word();
        op.divisor  = rand_word();
        if (pick < 30)
        begin
            // fully random pair
        end
        else if (pick < 48)
        begin
            op.divisor = small_signed(15);
        end
        else if (pick < 63)
        begin
            op.dividend = $signed(op.dividend) >>> $urandom_range(0, DW-1);
            op.divisor  = $signed(op.divisor) >>> $urandom_range(0, DW-1);
        end
        else if (pick < 72)
        begin
            // dividend usually smaller in magnitude than the divisor
            op.dividend = $signed(op.dividend) >>> $urandom_range(DW/2, DW-1);
            op.divisor  = $signed(op.divisor) >>> $urandom_range(0, DW/4);
            if ($urandom_range(0, 3) == 0)
                op.dividend = '0;
        end
        else if (pick < 79)
        begin
            op.divisor = '0;
            if ($urandom_range(0, 3) == 0)
                op.dividend = $urandom_range(0, 1) ? MOST_NEG : '0;
        end
        else if (pick < 85)
        begin
            op.dividend = MOST_NEG;
            if ($urandom_range(0, 1) == 0)
                op.divisor = MINUS_ONE;
        end
        else if (pick < 94)
        begin
            // land on or next to an exact multiple
            op.divisor  = small_signed(1000);
            k           = $signed(rand_word()) >>> $urandom_range(10, DW-1);
            op.dividend = op.divisor * k + small_signed(1) * $urandom_range(0, 1);
        end
        else
        begin
            op.divisor = $urandom_range(0, 1) ? MINUS_ONE : {{(DW-1){1'b0}}, 1'b1};
        end
        return op;
    endfunction

    task automatic queue_division(logic [DW-1:0] num, logic [DW-1:0] den);
        div_operands_t op;
        op.dividend = num;
        op.divisor  = den;
        pending_divisions.push_back(op);
    endtask

    task automatic queue_random(int count);
        repeat (count) pending_divisions.push_back(random_operands());
    endtask

    // Hold until every queued item is taken and every result has come back;
    // sample on the falling edge so the clocked processes have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_divisions.size() != 0 || s_tvalid || expected_quotients.size() != 0)
            @(negedge clk);
    endtask

    // Driver
    always @(posedge clk)
    begin : driver
        div_operands_t op;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_quotients.push_back(predict_division(s_tdata[DW-1:0],
                                                              s_tdata[2*DW-1:DW]));
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_divisions.size() != 0)
                begin
                    op = pending_divisions.pop_front();
                    s_tdata  <= S_BITS'({op.divisor, op.dividend});
                    s_tvalid <= 1'b1;
                    tx_gap   <= tx_idle_on ? pick_gap() : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready, with one long hold-off to back the chain up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && stall_trigger >= 0 && quotients_seen >= stall_trigger)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF;
            m_tready  <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_gap   <= rx_idle_on ? pick_gap() : 0;
        end
    end

    // Monitor
    always @(posedge clk)
    begin : monitor
        div_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            quotients_seen <= quotients_seen + 1;
            if (expected_quotients.size() == 0)
            begin
                $display("%0t: unexpected result, quotient %h flags %b",
                         $time, m_tdata, m_tuser);
                failures++;
            end
            else
            begin
                want = expected_quotients.pop_front();
                if (m_tdata[DW-1:0] !== want.quotient)
                begin
                    $display("%0t: quotient expected %h actual %h",
                             $time, want.quotient, m_tdata[DW-1:0]);
                    failures++;
                end
                if (m_tuser[sid_pkg::USER_DBZ_BIT] !== want.divide_by_zero)
                begin
                    $display("%0t: divide_by_zero expected %b actual %b", $time,
                             want.divide_by_zero, m_tuser[sid_pkg::USER_DBZ_BIT]);
                    failures++;
                end
                if (m_tuser[sid_pkg::USER_OVF_BIT] !== want.overflow)
                begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             want.overflow, m_tuser[sid_pkg::USER_OVF_BIT]);
                    failures++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        queue_division('0, 1);
        queue_division('0, MINUS_ONE);
        queue_division(MOST_NEG, MINUS_ONE);
        queue_division(MOST_NEG, 1);
        queue_division(MOST_NEG, 2);
        queue_division(MOST_NEG, MOST_NEG);
        queue_division(MOST_POS, MOST_POS);
        queue_division(MOST_POS, 1);
        queue_division(MOST_POS, MINUS_ONE);
        queue_division(MOST_POS, MOST_NEG);
        queue_division(MOST_NEG, MOST_POS);
        queue_division(MINUS_ONE, MOST_NEG);
        queue_division(MINUS_ONE, MINUS_ONE);
        queue_division(1, '0);
        queue_division(MOST_NEG, '0);
        queue_division('0, '0);
        queue_division(3, 7);
        queue_division(-3, 7);
        queue_division(3, -7);
        queue_division(7, -3);
        queue_division(-7, 3);
        queue_division(-7, -3);
        queue_division(100, 10);
        wait_drained();

        queue_random(200);
        wait_drained();

        // Back-to-back stretch; the receiver holds off partway through
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        stall_trigger = quotients_seen + 20;
        queue_random(120);
        wait_drained();

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        queue_random(130);
        wait_drained();

        repeat (LATENCY + 10) @(posedge clk);
        if (failures == 0 && expected_quotients.size() == 0)
        begin
            $display("signed_integer_divider verification clean");
        end
        else
        begin
            $display("signed_integer_divider verification failed");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("signed_integer_divider verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/sid_pkg.sv
rtl/sid_cell.sv
rtl/signed_integer_divider.sv
verif/tb_signed_integer_divider.sv
